// ===== hdl/positional_list_store_top_assert.svh =====
// ----------------------------------------------------------------------------
// positional list store assertion macros
// concurrent assertion wrappers on clk_i, disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_STORE_TOP_ASSERT_SVH
`define POSITIONAL_LIST_STORE_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define PLS_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define PLS_ASSERT(lbl, prop) \
  `PLS_ASSERT_MSG(lbl, prop, "positional list store check failed")
`else
`define PLS_ASSERT_MSG(lbl, prop, msg)
`define PLS_ASSERT(lbl, prop)
`endif

`endif

// ===== hdl/pls_pkg.sv =====
// ----------------------------------------------------------------------------
// pls_pkg
// shared constants and types of the positional list store
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pls_pkg;

  localparam int CAPACITY    = 32;
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int CMP_W       = ((CNT_W > 6) ? CNT_W : 6) + 1;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 40;

  typedef enum logic [2:0] {
    MODE_INS_FRONT = 3'd0,
    MODE_INS_BACK  = 3'd1,
    MODE_INS_POS   = 3'd2,
    MODE_DEL_FRONT = 3'd3,
    MODE_DEL_BACK  = 3'd4,
    MODE_DEL_POS   = 3'd5,
    MODE_LIST      = 3'd6
  } mode_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_RANGE = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_INS_WR,
    ST_LIST_RD,
    ST_LIST_OUT,
    ST_RESP
  } state_e;

endpackage

// ===== hdl/positional_list_store_top.sv =====
// sequence: errors and mode 7 go from accept straight to ST_RESP; inserts pass ST_SHIFT,
//   ST_INS_WR and ST_RESP, deletes ST_SHIFT and ST_RESP, with entries moved in ST_SHIFT
// list all: entry by entry, each is read in ST_LIST_RD, then loaded to the output in ST_LIST_OUT
// requests: one at a time, taken the cycle after its last result is loaded;
//   a stall on m_tready holds back that load and the return to ST_IDLE
// reset: asynchronous active-low rst_ni empties the list; entry memory is not cleared
// ----------------------------------------------------------------------------
// positional_list_store_top
// ordered list of signed 32-bit values with positional insert, delete and
// list-all, shifting entries one per cycle through a one-read-port, one-write-port memory
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "positional_list_store_top_assert.svh"

module positional_list_store_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [pls_pkg::IN_TDATA_W-1:0]  s_tdata,  // mode[2:0], value[34:3], position[40:35]
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [pls_pkg::OUT_TDATA_W-1:0] m_tdata,  // status[1:0], item[33:2], count[39:34]
  output logic                            m_tlast   // last
);
  import pls_pkg::*;

  logic [2:0]        in_mode;
  logic [31:0]       in_value;
  logic [5:0]        in_pos;
  logic [CMP_W-1:0]  pos_ext, cnt_ext;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [IDX_W-1:0]  rptr_q, rptr_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [IDX_W-1:0]  waddr_q, waddr_d;
  logic              ins_q, ins_d;
  logic              first_q, first_d;
  logic              pend_q, pend_d;
  logic              capt_q, capt_d;
  logic [31:0]       value_q, value_d;
  logic [31:0]       item_q;
  status_e           status_q, status_d;

  logic              m_valid_q, m_valid_d;
  logic [1:0]        m_status_q, m_status_d;
  logic [31:0]       m_item_q, m_item_d;
  logic [5:0]        m_count_q, m_count_d;
  logic              m_last_q, m_last_d;

  logic [31:0]       mem [CAPACITY];
  logic [31:0]       rdata_q;
  logic              rd_en;
  logic [IDX_W-1:0]  raddr;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [31:0]       wr_data;
  logic              out_free;

  assign in_mode  = s_tdata[2:0];
  assign in_value = s_tdata[34:3];
  assign in_pos   = s_tdata[40:35];
  assign pos_ext  = CMP_W'(in_pos);
  assign cnt_ext  = CMP_W'(cnt_q);

  assign s_tready = (state_q == ST_IDLE);
  assign out_free = !m_valid_q || m_tready;

  assign m_tvalid = m_valid_q;
  assign m_tlast  = m_last_q;
  assign m_tdata  = {m_count_q, m_item_q, m_status_q};

  // pending shift data is written back, except the captured deleted value; ST_INS_WR writes the new value
  assign wr_en   = (state_q == ST_INS_WR) || (pend_q && !capt_q);
  assign wr_addr = (state_q == ST_INS_WR) ? idx_q : waddr_q;
  assign wr_data = (state_q == ST_INS_WR) ? value_q : rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_q && capt_q) begin
      item_q <= rdata_q;
    end else if (state_q == ST_IDLE) begin
      item_q <= '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      pend_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      pend_q    <= pend_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q      <= rem_d;
    rptr_q     <= rptr_d;
    idx_q      <= idx_d;
    waddr_q    <= waddr_d;
    ins_q      <= ins_d;
    first_q    <= first_d;
    capt_q     <= capt_d;
    value_q    <= value_d;
    status_q   <= status_d;
    m_status_q <= m_status_d;
    m_item_q   <= m_item_d;
    m_count_q  <= m_count_d;
    m_last_q   <= m_last_d;
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    rem_d      = rem_q;
    rptr_d     = rptr_q;
    idx_d      = idx_q;
    waddr_d    = waddr_q;
    ins_d      = ins_q;
    first_d    = first_q;
    pend_d     = 1'b0;
    capt_d     = 1'b0;
    value_d    = value_q;
    status_d   = status_q;
    rd_en      = 1'b0;
    raddr      = rptr_q;
    m_valid_d  = m_valid_q && !m_tready;
    m_status_d = m_status_q;
    m_item_d   = m_item_q;
    m_count_d  = m_count_q;
    m_last_d   = m_last_q;

    unique case (state_q)
      ST_IDLE: begin
        if (s_tvalid) begin
          value_d  = in_value;
          status_d = STAT_OK;
          first_d  = 1'b1;
          state_d  = ST_RESP;
          unique case (mode_e'(in_mode)) inside
            MODE_INS_FRONT, MODE_INS_BACK, MODE_INS_POS: begin
              ins_d  = 1'b1;
              rptr_d = IDX_W'(cnt_q - CNT_W'(1));
              if (cnt_q >= CNT_W'(CAPACITY)) begin
                status_d = STAT_FULL;
              end else if (in_mode == MODE_INS_FRONT) begin
                idx_d   = '0;
                rem_d   = cnt_q;
                state_d = ST_SHIFT;
              end else if (in_mode == MODE_INS_BACK) begin
                idx_d   = IDX_W'(cnt_q);
                rem_d   = '0;
                state_d = ST_SHIFT;
              end else if (in_pos == '0 || pos_ext > cnt_ext + CMP_W'(1)) begin
                status_d = STAT_RANGE;
              end else begin
                idx_d   = IDX_W'(pos_ext - CMP_W'(1));
                rem_d   = CNT_W'(cnt_ext - (pos_ext - CMP_W'(1)));
                state_d = ST_SHIFT;
              end
            end
            MODE_DEL_FRONT, MODE_DEL_BACK, MODE_DEL_POS: begin
              ins_d = 1'b0;
              if (cnt_q == '0) begin
                status_d = STAT_EMPTY;
              end else if (in_mode == MODE_DEL_FRONT) begin
                rptr_d  = '0;
                rem_d   = cnt_q;
                state_d = ST_SHIFT;
              end else if (in_mode == MODE_DEL_BACK) begin
                rptr_d  = IDX_W'(cnt_q - CNT_W'(1));
                rem_d   = CNT_W'(1);
                state_d = ST_SHIFT;
              end else if (in_pos == '0 || pos_ext > cnt_ext) begin
                status_d = STAT_RANGE;
              end else begin
                rptr_d  = IDX_W'(pos_ext - CMP_W'(1));
                rem_d   = CNT_W'(cnt_ext - (pos_ext - CMP_W'(1)));
                state_d = ST_SHIFT;
              end
            end
            MODE_LIST: begin
              rptr_d = '0;
              if (cnt_q == '0) begin
                status_d = STAT_EMPTY;
              end else begin
                state_d = ST_LIST_RD;
              end
            end
            default: begin
              status_d = STAT_OK;
            end
          endcase
        end
      end
      ST_SHIFT: begin
        if (rem_q != '0) begin
          rd_en   = 1'b1;
          pend_d  = 1'b1;
          capt_d  = first_q && !ins_q;
          first_d = 1'b0;
          rem_d   = rem_q - CNT_W'(1);
          waddr_d = ins_q ? rptr_q + IDX_W'(1) : rptr_q - IDX_W'(1);
          rptr_d  = ins_q ? rptr_q - IDX_W'(1) : rptr_q + IDX_W'(1);
        end else if (!pend_q) begin
          if (ins_q) begin
            state_d = ST_INS_WR;
          end else begin
            cnt_d   = cnt_q - CNT_W'(1);
            state_d = ST_RESP;
          end
        end
      end
      ST_INS_WR: begin
        cnt_d   = cnt_q + CNT_W'(1);
        state_d = ST_RESP;
      end
      ST_LIST_RD: begin
        rd_en   = 1'b1;
        state_d = ST_LIST_OUT;
      end
      ST_LIST_OUT: begin
        if (out_free) begin
          m_valid_d  = 1'b1;
          m_status_d = STAT_OK;
          m_item_d   = rdata_q;
          m_count_d  = 6'(cnt_q);
          m_last_d   = (CNT_W'(rptr_q) + CNT_W'(1) == cnt_q);
          if (CNT_W'(rptr_q) + CNT_W'(1) == cnt_q) begin
            state_d = ST_IDLE;
          end else begin
            rptr_d  = rptr_q + IDX_W'(1);
            state_d = ST_LIST_RD;
          end
        end
      end
      ST_RESP: begin
        if (out_free) begin
          m_valid_d  = 1'b1;
          m_status_d = status_q;
          m_item_d   = item_q;
          m_count_d  = 6'(cnt_q);
          m_last_d   = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  `PLS_ASSERT(a_cnt_bound, cnt_q <= CNT_W'(CAPACITY))
  `PLS_ASSERT(a_pend_in_shift, pend_q |-> state_q == ST_SHIFT)
  `PLS_ASSERT(a_cnt_change, !$stable(cnt_q) |-> $past(state_q == ST_SHIFT || state_q == ST_INS_WR))
  `PLS_ASSERT(a_busy_not_ready, state_q == ST_SHIFT |-> !s_tready)

endmodule
